// File: hdl/movdec_pkg.sv
// Shared types and opcode constants for the MOV instruction byte decoder.
`default_nettype none

package movdec_pkg;

  localparam logic [2:0] FORM_RM_RM   = 3'd0;
  localparam logic [2:0] FORM_IMM_RM  = 3'd1;
  localparam logic [2:0] FORM_IMM_REG = 3'd2;
  localparam logic [2:0] FORM_MEM_ACC = 3'd3;
  localparam logic [2:0] FORM_ACC_MEM = 3'd4;
  localparam logic [2:0] FORM_RM_SEG  = 3'd5;
  localparam logic [2:0] FORM_SEG_RM  = 3'd6;

  localparam logic [5:0] OP_RM_RM   = 6'b100010;
  localparam logic [6:0] OP_IMM_RM  = 7'b1100011;
  localparam logic [3:0] OP_IMM_REG = 4'b1011;
  localparam logic [6:0] OP_MEM_ACC = 7'b1010000;
  localparam logic [6:0] OP_ACC_MEM = 7'b1010001;
  localparam logic [7:0] OP_RM_SEG  = 8'b10001110;
  localparam logic [7:0] OP_SEG_RM  = 8'b10001100;
  localparam logic [2:0] RM_DIRECT  = 3'b110;

  localparam logic [2:0] MAX_LENGTH = 3'd6;

  typedef struct packed {
    logic        collect;
    logic [2:0]  form;
    logic [1:0]  opbits;
    logic [7:0]  modrm;
    logic [15:0] disp;
    logic [15:0] imm;
    logic [2:0]  taken;
    logic [2:0]  needed;
  } dec_state_t;

  typedef struct packed {
    logic        emit;
    logic [2:0]  form;
    logic        dir_bit;
    logic        wide;
    logic [1:0]  mode_bits;
    logic [2:0]  reg_field;
    logic [2:0]  rm_field;
    logic [15:0] displacement;
    logic [15:0] immediate;
    logic [2:0]  length;
    logic        truncated;
  } dec_result_t;

endpackage

`default_nettype wire

// File: hdl/mov_instruction_byte_decoder_core.sv
// Top level of the MOV instruction byte decoder: input register, decode step, result register.
// A record's last byte goes via the input register and decode step into the result register.
// Throughput: one byte per cycle unless output stalls; input and result registers hold one item.
// Reset: synchronous, active high; clears both registers and returns the decoder to idle.
// Bytes that start no MOV form while idle are dropped without a record.
`default_nettype none

module mov_instruction_byte_decoder_core
  import movdec_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // code_byte[7:0]
  input  wire logic        s_tlast,   // stream_end
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // form[2:0], dir_bit[3], wide[4], mode_bits[6:5], reg_field[9:7], rm_field[12:10],
  // displacement[28:13], immediate[44:29], length[47:45]
  output logic [47:0]      m_tdata,
  output logic             m_tuser    // truncated
);

  logic        in_valid;
  logic [7:0]  in_byte;
  logic        in_last;
  logic        advance;
  dec_state_t  state;
  dec_state_t  state_next;
  dec_result_t result;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  movdec_step u_step (
    .code_byte  (in_byte),
    .stream_end (in_last),
    .state      (state),
    .state_next (state_next),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (advance) begin
        state <= state_next;
      end
      if (advance && result.emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
    if (advance && result.emit) begin
      m_tdata <= {result.length, result.immediate, result.displacement, result.rm_field,
                  result.reg_field, result.mode_bits, result.wide, result.dir_bit, result.form};
      m_tuser <= result.truncated;
    end
  end

  a_length_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[47:45] != 3'd0 && m_tdata[47:45] <= MAX_LENGTH))
    else $error("record length out of range");

  a_segment_single_byte: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[2:0] == FORM_RM_SEG || m_tdata[2:0] == FORM_SEG_RM))
      |-> (m_tdata[47:45] == 3'd1 && !m_tuser))
    else $error("segment form record is not a complete single byte");

  a_collect_pending: assert property (@(posedge clk) disable iff (rst)
    state.collect |-> (state.taken < state.needed))
    else $error("decoder collecting with no bytes outstanding");

  a_stall_holds_state: assert property (@(posedge clk) disable iff (rst)
    (in_valid && m_tvalid && !m_tready) |=> $stable(state))
    else $error("decoder state moved while the result register was blocked");

endmodule

`default_nettype wire

// File: hdl/movdec_step.sv
// Per-byte decode step: next decoder state and the record, if any, that the byte completes.
`default_nettype none

module movdec_step
  import movdec_pkg::*;
(
  input  wire logic [7:0]  code_byte,
  input  wire logic        stream_end,
  input  wire dec_state_t  state,
  output dec_state_t       state_next,
  output dec_result_t      result
);

  function automatic logic [2:0] disp_len(input logic [2:0] form, input logic [7:0] modrm);
    logic [2:0] len;
    len = 3'd0;
    if (form == FORM_RM_RM || form == FORM_IMM_RM) begin
      unique case (modrm[7:6])
        2'd0: len = (modrm[2:0] == RM_DIRECT) ? 3'd2 : 3'd0;
        2'd1: len = 3'd1;
        2'd2: len = 3'd2;
        default: len = 3'd0;
      endcase
    end else if (form == FORM_MEM_ACC || form == FORM_ACC_MEM) begin
      len = 3'd2;
    end
    return len;
  endfunction

  function automatic logic [2:0] disp_start(input logic [2:0] form);
    return (form == FORM_RM_RM || form == FORM_IMM_RM) ? 3'd2 : 3'd1;
  endfunction

  function automatic logic [2:0] total_len(input logic [2:0] form, input logic [1:0] opbits,
                                           input logic [7:0] modrm);
    logic [2:0] il;
    il = (form == FORM_IMM_RM || form == FORM_IMM_REG) ? {2'b00, 1'b1} + {2'b00, opbits[0]}
                                                        : 3'd0;
    if (form == FORM_RM_SEG || form == FORM_SEG_RM) begin
      return 3'd1;
    end
    return disp_start(form) + disp_len(form, modrm) + il;
  endfunction

  logic       matched;
  logic [2:0] mform;
  logic [2:0] ds;
  logic [2:0] dl;
  logic [2:0] is;
  logic       done;
  logic       active;
  logic       has_modrm;

  always_comb begin
    matched = 1'b1;
    mform   = FORM_RM_RM;
    priority if (code_byte[7:2] == OP_RM_RM) begin
      mform = FORM_RM_RM;
    end else if (code_byte[7:1] == OP_IMM_RM) begin
      mform = FORM_IMM_RM;
    end else if (code_byte[7:4] == OP_IMM_REG) begin
      mform = FORM_IMM_REG;
    end else if (code_byte[7:1] == OP_MEM_ACC) begin
      mform = FORM_MEM_ACC;
    end else if (code_byte[7:1] == OP_ACC_MEM) begin
      mform = FORM_ACC_MEM;
    end else if (code_byte == OP_RM_SEG) begin
      mform = FORM_RM_SEG;
    end else if (code_byte == OP_SEG_RM) begin
      mform = FORM_SEG_RM;
    end else begin
      matched = 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    ds = disp_start(state.form);
    dl = disp_len(state.form, state.modrm);
    is = ds + dl;
    if (!state.collect) begin
      if (matched) begin
        state_next.form  = mform;
        state_next.modrm = 8'h00;
        state_next.disp  = 16'h0000;
        state_next.imm   = 16'h0000;
        unique case (mform)
          FORM_RM_RM: state_next.opbits = code_byte[1:0];
          FORM_IMM_REG: begin
            state_next.opbits = {1'b0, code_byte[3]};
            state_next.modrm  = {2'b00, code_byte[2:0], 3'b000};
          end
          FORM_IMM_RM, FORM_MEM_ACC, FORM_ACC_MEM: state_next.opbits = {1'b0, code_byte[0]};
          default: state_next.opbits = 2'b00;
        endcase
        state_next.taken  = 3'd1;
        state_next.needed = (mform == FORM_RM_RM || mform == FORM_IMM_RM) ? 3'd2
                          : total_len(mform, state_next.opbits, state_next.modrm);
      end
    end else begin
      if ((state.form == FORM_RM_RM || state.form == FORM_IMM_RM) && state.taken == 3'd1) begin
        state_next.modrm  = code_byte;
        state_next.needed = total_len(state.form, state.opbits, code_byte);
      end else if (state.taken >= ds && state.taken < is) begin
        if (dl == 3'd1) begin
          state_next.disp = {{8{code_byte[7]}}, code_byte};
        end else if (state.taken == ds) begin
          state_next.disp = {state.disp[15:8], code_byte};
        end else begin
          state_next.disp = {code_byte, state.disp[7:0]};
        end
      end else if (state.taken == is) begin
        state_next.imm = {state.imm[15:8], code_byte};
      end else if (state.taken == is + 3'd1) begin
        state_next.imm = {code_byte, state.imm[7:0]};
      end
      state_next.taken = state.taken + 3'd1;
    end

    active    = state.collect || matched;
    done      = state_next.taken >= state_next.needed;
    has_modrm = state_next.form == FORM_RM_RM || state_next.form == FORM_IMM_RM;

    result.emit         = active && (done || stream_end);
    result.form         = state_next.form;
    result.dir_bit      = (state_next.form == FORM_RM_RM) ? state_next.opbits[1] : 1'b0;
    result.wide         = state_next.opbits[0];
    result.mode_bits    = has_modrm ? state_next.modrm[7:6] : 2'b00;
    result.reg_field    = (has_modrm || state_next.form == FORM_IMM_REG) ?
                          state_next.modrm[5:3] : 3'b000;
    result.rm_field     = has_modrm ? state_next.modrm[2:0] : 3'b000;
    result.displacement = state_next.disp;
    result.immediate    = state_next.imm;
    result.length       = state_next.taken;
    result.truncated    = !done;

    state_next.collect  = active && !result.emit;
  end

endmodule

`default_nettype wire

// File: tb/sv/mov_instruction_byte_decoder_core_tb.sv
// Self-checking testbench for the MOV instruction byte decoder core.
`default_nettype none

module mov_instruction_byte_decoder_core_tb;
  import movdec_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int LONG_HOLD   = 300;
  localparam int TAIL_CYCLES = 8;

  typedef struct packed {
    logic [2:0]  form;
    logic        dir_bit;
    logic        wide;
    logic [1:0]  mode_bits;
    logic [2:0]  reg_field;
    logic [2:0]  rm_field;
    logic [15:0] displacement;
    logic [15:0] immediate;
    logic [2:0]  length;
    logic        truncated;
  } mov_record_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic        m_tuser;

  mov_instruction_byte_decoder_core uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Decoder state as the testbench tracks it.
  logic        dec_busy = 1'b0;
  logic [2:0]  dec_form = '0;
  logic [1:0]  dec_opbits = '0;
  logic [7:0]  dec_modrm = '0;
  logic [15:0] dec_disp = '0;
  logic [15:0] dec_imm = '0;
  logic [2:0]  dec_taken = '0;
  logic [2:0]  dec_needed = '0;

  mov_record_t expected_records[$];
  logic [7:0]  code_bytes[$];

  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  int hold_trigger = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int err_count = 0;
  int records_checked = 0;
  int truncated_seen = 0;
  int bytes_sent = 0;
  logic [6:0] forms_seen = '0;

  function automatic logic has_modrm();
    return dec_form <= FORM_IMM_RM;
  endfunction

  function automatic logic [2:0] disp_bytes();
    if (has_modrm()) begin
      case (dec_modrm[7:6])
        2'd0: return (dec_modrm[2:0] == RM_DIRECT) ? 3'd2 : 3'd0;
        2'd1: return 3'd1;
        2'd2: return 3'd2;
        default: return 3'd0;
      endcase
    end
    if (dec_form == FORM_MEM_ACC || dec_form == FORM_ACC_MEM) return 3'd2;
    return 3'd0;
  endfunction

  function automatic logic [2:0] imm_bytes();
    if (dec_form == FORM_IMM_RM || dec_form == FORM_IMM_REG) return 3'd1 + {2'b00, dec_opbits[0]};
    return 3'd0;
  endfunction

  function automatic logic [2:0] instr_length();
    if (dec_form >= FORM_RM_SEG) return 3'd1;
    return (has_modrm() ? 3'd2 : 3'd1) + disp_bytes() + imm_bytes();
  endfunction

  // Advances the tracked decoder by one byte; returns 1 when a record is due.
  function automatic bit decode_step(input logic [7:0] b, input logic last,
                                     output mov_record_t rec);
    logic [2:0] ds;
    logic [2:0] dl;
    logic [2:0] ist;
    logic [2:0] k;
    logic [2:0] f;
    bit         hit;
    logic       mr;
    rec = '0;
    if (!dec_busy) begin
      hit = 1'b1;
      f = FORM_RM_RM;
      if (b[7:2] == OP_RM_RM) f = FORM_RM_RM;
      else if (b[7:1] == OP_IMM_RM) f = FORM_IMM_RM;
      else if (b[7:4] == OP_IMM_REG) f = FORM_IMM_REG;
      else if (b[7:1] == OP_MEM_ACC) f = FORM_MEM_ACC;
      else if (b[7:1] == OP_ACC_MEM) f = FORM_ACC_MEM;
      else if (b == OP_RM_SEG) f = FORM_RM_SEG;
      else if (b == OP_SEG_RM) f = FORM_SEG_RM;
      else hit = 1'b0;
      if (!hit) return 1'b0;
      dec_form = f;
      dec_modrm = '0;
      dec_disp = '0;
      dec_imm = '0;
      case (f)
        FORM_RM_RM: dec_opbits = b[1:0];
        FORM_IMM_REG: begin
          dec_opbits = {1'b0, b[3]};
          dec_modrm = {2'b00, b[2:0], 3'b000};
        end
        FORM_IMM_RM, FORM_MEM_ACC, FORM_ACC_MEM: dec_opbits = {1'b0, b[0]};
        default: dec_opbits = 2'b00;
      endcase
      dec_taken = 3'd1;
      dec_needed = has_modrm() ? 3'd2 : instr_length();
    end else begin
      k = dec_taken;
      ds = has_modrm() ? 3'd2 : 3'd1;
      dl = disp_bytes();
      ist = ds + dl;
      if (has_modrm() && k == 3'd1) begin
        dec_modrm = b;
        dec_needed = instr_length();
      end else if (k >= ds && k < ist) begin
        if (dl == 3'd1) dec_disp = {{8{b[7]}}, b};
        else if (k == ds) dec_disp[7:0] = b;
        else dec_disp[15:8] = b;
      end else if (k == ist) begin
        dec_imm[7:0] = b;
      end else if (k == ist + 3'd1) begin
        dec_imm[15:8] = b;
      end
      dec_taken = dec_taken + 3'd1;
    end
    if (dec_taken >= dec_needed || last) begin
      mr = has_modrm();
      rec.form = dec_form;
      rec.dir_bit = (dec_form == FORM_RM_RM) ? dec_opbits[1] : 1'b0;
      rec.wide = dec_opbits[0];
      rec.mode_bits = mr ? dec_modrm[7:6] : 2'b00;
      rec.reg_field = (mr || dec_form == FORM_IMM_REG) ? dec_modrm[5:3] : 3'd0;
      rec.rm_field = mr ? dec_modrm[2:0] : 3'd0;
      rec.displacement = dec_disp;
      rec.immediate = dec_imm;
      rec.length = dec_taken;
      rec.truncated = !(dec_taken >= dec_needed);
      dec_busy = 1'b0;
      return 1'b1;
    end
    dec_busy = 1'b1;
    return 1'b0;
  endfunction

  task automatic send_item(input logic [7:0] b, input logic last);
    mov_record_t rec;
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
    bytes_sent++;
    if (decode_step(b, last, rec)) expected_records.push_back(rec);
  endtask

  // Appends one MOV instruction of the given form to code_bytes.
  task automatic build_mov(input logic [2:0] f, input logic [7:0] op, input logic [7:0] modrm,
                           input logic [15:0] d, input logic [15:0] im);
    int dl;
    case (f)
      FORM_RM_RM, FORM_IMM_RM: begin
        code_bytes.push_back(f == FORM_RM_RM ? {OP_RM_RM, op[1:0]} : {OP_IMM_RM, op[0]});
        code_bytes.push_back(modrm);
        case (modrm[7:6])
          2'd0: dl = (modrm[2:0] == RM_DIRECT) ? 2 : 0;
          2'd1: dl = 1;
          2'd2: dl = 2;
          default: dl = 0;
        endcase
        if (dl >= 1) code_bytes.push_back(d[7:0]);
        if (dl == 2) code_bytes.push_back(d[15:8]);
        if (f == FORM_IMM_RM) begin
          code_bytes.push_back(im[7:0]);
          if (op[0]) code_bytes.push_back(im[15:8]);
        end
      end
      FORM_IMM_REG: begin
        code_bytes.push_back({OP_IMM_REG, op[3:0]});
        code_bytes.push_back(im[7:0]);
        if (op[3]) code_bytes.push_back(im[15:8]);
      end
      FORM_MEM_ACC, FORM_ACC_MEM: begin
        code_bytes.push_back(f == FORM_MEM_ACC ? {OP_MEM_ACC, op[0]} : {OP_ACC_MEM, op[0]});
        code_bytes.push_back(d[7:0]);
        code_bytes.push_back(d[15:8]);
      end
      FORM_RM_SEG: code_bytes.push_back(OP_RM_SEG);
      default: code_bytes.push_back(OP_SEG_RM);
    endcase
  endtask

  // Sends code_bytes with the stream ending at index cut; nothing after the cut is sent.
  task automatic send_code(input int cut);
    int i;
    for (i = 0; i < code_bytes.size(); i++) begin
      send_item(code_bytes[i], i == cut);
      if (i == cut) break;
    end
    code_bytes.delete();
  endtask

  task automatic send_random_mov(input bit allow_cut);
    int r;
    build_mov(3'($urandom_range(0, 6)), 8'($urandom), 8'($urandom), 16'($urandom),
              16'($urandom));
    r = allow_cut ? $urandom_range(9) : 9;
    if (r == 0) send_code($urandom_range(0, code_bytes.size() - 1));
    else if (r == 1) send_code(code_bytes.size() - 1);
    else send_code(-1);
  endtask

  task automatic test_directed_forms();
    build_mov(FORM_RM_RM, 8'h00, 8'hC0, 16'h0000, 16'h0000);
    build_mov(FORM_RM_RM, 8'h03, 8'h3E, 16'hFFFF, 16'h0000);
    build_mov(FORM_RM_RM, 8'h01, 8'h7F, 16'h0080, 16'h0000);
    build_mov(FORM_RM_RM, 8'h02, 8'h45, 16'h007F, 16'h0000);
    build_mov(FORM_RM_RM, 8'h03, 8'hBF, 16'h1234, 16'h0000);
    build_mov(FORM_IMM_RM, 8'h00, 8'h00, 16'h0000, 16'h00FF);
    build_mov(FORM_IMM_RM, 8'h01, 8'h86, 16'hFFFF, 16'hFFFF);
    build_mov(FORM_IMM_RM, 8'h01, 8'hFF, 16'h0000, 16'h8001);
    build_mov(FORM_IMM_REG, 8'h00, 8'h00, 16'h0000, 16'h0000);
    build_mov(FORM_IMM_REG, 8'h0F, 8'h00, 16'h0000, 16'hFFFF);
    build_mov(FORM_MEM_ACC, 8'h00, 8'h00, 16'h0000, 16'h0000);
    build_mov(FORM_ACC_MEM, 8'h01, 8'h00, 16'hFFFF, 16'h0000);
    build_mov(FORM_RM_SEG, 8'h00, 8'h00, 16'h0000, 16'h0000);
    build_mov(FORM_SEG_RM, 8'h00, 8'h00, 16'h0000, 16'h0000);
    send_code(-1);
  endtask

  task automatic test_special_cases();
    // Bytes that start no instruction are dropped, even at the end of a stream.
    send_item(8'h00, 1'b1);
    send_item(8'hFF, 1'b1);
    send_item(8'h8D, 1'b0);
    // A stream ending inside the displacement, on the opcode alone, and on the last byte.
    build_mov(FORM_IMM_RM, 8'h01, 8'h86, 16'hA5C3, 16'h5A3C);
    send_code(3);
    build_mov(FORM_ACC_MEM, 8'h01, 8'h00, 16'h4321, 16'h0000);
    send_code(0);
    build_mov(FORM_RM_RM, 8'h01, 8'h06, 16'hBEEF, 16'h0000);
    send_code(3);
    build_mov(FORM_RM_SEG, 8'h00, 8'h00, 16'h0000, 16'h0000);
    send_code(0);
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int count);
    int goal;
    goal = bytes_sent + count;
    src_idle_pct = idle_pct;
    snk_stall_pct = stall_pct;
    while (bytes_sent < goal) begin
      if ($urandom_range(99) < 15) send_item(8'($urandom), $urandom_range(9) == 0);
      else send_random_mov(1'b1);
    end
  endtask

  task automatic test_output_hold();
    int i;
    src_idle_pct = 0;
    snk_stall_pct = 0;
    hold_trigger <= hold_trigger + 1;
    for (i = 0; i < 40; i++) send_random_mov(1'b0);
  endtask

  always @(posedge clk) begin
    if (hold_trigger != hold_seen) begin
      hold_seen <= hold_trigger;
      hold_left <= LONG_HOLD;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  always @(posedge clk) begin
    mov_record_t act;
    mov_record_t exp_rec;
    if (!rst && m_tvalid && m_tready) begin
      act = {m_tdata[2:0], m_tdata[3], m_tdata[4], m_tdata[6:5], m_tdata[9:7],
             m_tdata[12:10], m_tdata[28:13], m_tdata[44:29], m_tdata[47:45], m_tuser};
      if (expected_records.size() == 0) begin
        if (err_count < 10)
          $display("ERROR: unexpected record form=%0d len=%0d trunc=%0b",
                   act.form, act.length, act.truncated);
        err_count++;
      end else begin
        exp_rec = expected_records.pop_front();
        records_checked++;
        forms_seen[exp_rec.form] = 1'b1;
        if (exp_rec.truncated) truncated_seen++;
        if (act.form !== exp_rec.form || act.dir_bit !== exp_rec.dir_bit ||
            act.wide !== exp_rec.wide || act.mode_bits !== exp_rec.mode_bits ||
            act.reg_field !== exp_rec.reg_field || act.rm_field !== exp_rec.rm_field ||
            act.displacement !== exp_rec.displacement ||
            act.immediate !== exp_rec.immediate || act.length !== exp_rec.length ||
            act.truncated !== exp_rec.truncated) begin
          if (err_count < 10) begin
            $display("ERROR: record %0d expected form=%0d d=%b w=%b mod=%0d reg=%0d rm=%0d",
                     records_checked, exp_rec.form, exp_rec.dir_bit, exp_rec.wide,
                     exp_rec.mode_bits, exp_rec.reg_field, exp_rec.rm_field);
            $display("       disp=%h imm=%h len=%0d trunc=%b", exp_rec.displacement,
                     exp_rec.immediate, exp_rec.length, exp_rec.truncated);
            $display("  actual form=%0d d=%b w=%b mod=%0d reg=%0d rm=%0d", act.form,
                     act.dir_bit, act.wide, act.mode_bits, act.reg_field, act.rm_field);
            $display("       disp=%h imm=%h len=%0d trunc=%b", act.displacement,
                     act.immediate, act.length, act.truncated);
          end
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no item moved for %0d cycles.", QUIET_LIMIT);
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_forms();
    test_special_cases();
    test_random_traffic(0, 0, 170);
    test_random_traffic(74, 0, 170);
    test_random_traffic(0, 74, 170);
    test_random_traffic(18, 18, 170);
    test_output_hold();
    s_tvalid <= 1'b0;
    s_tlast <= 1'b0;
    while (expected_records.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Checked %0d records (%0d truncated, forms mask %b) from %0d code bytes,",
             records_checked, truncated_seen, forms_seen, bytes_sent);
    $display("across idle and stall mixes and a %0d-cycle output hold-off.", LONG_HOLD);
    if (err_count == 0 && expected_records.size() == 0) begin
      $display("PASS");
    end else begin
      $display("Mismatches: %0d", err_count);
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
